// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the frame allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that expr holds at every clock edge out of reset.
`define BFA_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check that cons holds in the cycle after ante.
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BFA_ASSERT(lbl, expr, msg)
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/bfa_pkg.sv =====
// Package: sizes, codes and shared types of the bitmap frame allocator.
`timescale 1ns / 1ps
package bfa_pkg;

  localparam int FRAME_COUNT = 4096;
  localparam int FRAME_BYTES = 4096;  // power of two

  localparam int ADDR_W      = 32;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int WORD_W      = 32;
  localparam int BIT_W       = 5;
  localparam int MAP_WORDS   = (FRAME_COUNT + WORD_W - 1) / WORD_W;
  localparam int WADDR_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int FRAME_IDX_W = WADDR_W + BIT_W;
  localparam int LIM_W       = FRAME_IDX_W + 1;
  localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);

  // Frames whose start address fits in the address space, capped at the map size.
  localparam longint unsigned ADDR_SPAN   = 64'd1 << ADDR_W;
  localparam longint unsigned SPAN_FRAMES = (ADDR_SPAN + FRAME_BYTES - 1) / FRAME_BYTES;
  localparam longint unsigned USABLE_FRAMES =
    (SPAN_FRAMES < FRAME_COUNT) ? SPAN_FRAMES : FRAME_COUNT;
  localparam logic [LIM_W-1:0] USABLE_LIM = LIM_W'(USABLE_FRAMES);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_INIT  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RMW,
    S_INIT,
    S_FIN
  } state_t;

  // Result of the shared word unit for one map word.
  typedef struct packed {
    logic              found;
    logic [BIT_W-1:0]  bit_idx;
    logic [WORD_W-1:0] set_word;
    logic [WORD_W-1:0] lim_mask;
  } word_res_t;

endpackage

// ===== hdl/bfa_if.sv =====
// Channel interfaces: request channel and result channel.
`timescale 1ns / 1ps
interface bfa_in_if;
  logic                        valid;
  logic                        ready;
  logic [bfa_pkg::OP_W-1:0]    operation;
  logic [bfa_pkg::ADDR_W-1:0]  address;

  modport source (output valid, output operation, output address, input ready);
  modport sink   (input valid, input operation, input address, output ready);
endinterface

interface bfa_out_if;
  logic                          valid;
  logic                          ready;
  logic [bfa_pkg::STATUS_W-1:0]  status;
  logic [bfa_pkg::ADDR_W-1:0]    frame_address;
  logic                          is_free;

  modport source (output valid, output status, output frame_address, output is_free,
                  input ready);
  modport sink   (input valid, input status, input frame_address, input is_free,
                  output ready);
endinterface

// ===== hdl/bfa_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/bfa_word_unit.sv =====
// Shared word unit: limit mask, lowest free frame search and set-bit word.
`timescale 1ns / 1ps
module bfa_word_unit (
  input  logic [bfa_pkg::WORD_W-1:0]  word,
  input  logic [bfa_pkg::WADDR_W-1:0] word_idx,
  input  logic [bfa_pkg::LIM_W-1:0]   limit,
  output bfa_pkg::word_res_t          res
);
  import bfa_pkg::*;

  logic [LIM_W:0]      base;
  logic [LIM_W:0]      lim_ext;
  logic [WORD_W-1:0]   mask;
  logic [WORD_W-1:0]   free_bits;
  logic                found;
  logic [BIT_W-1:0]    bit_idx;

  // Bits of this word whose frame number lies below limit.
  always_comb begin
    base    = (LIM_W + 1)'({word_idx, {BIT_W{1'b0}}});
    lim_ext = (LIM_W + 1)'(limit);
    if (lim_ext >= base + (LIM_W + 1)'(WORD_W)) begin
      mask = '1;
    end else if (lim_ext <= base) begin
      mask = '0;
    end else begin
      mask = (WORD_W'(1) << limit[BIT_W-1:0]) - WORD_W'(1);
    end
  end

  // Lowest free usable bit: walk down so the lowest hit wins.
  always_comb begin
    free_bits = ~word & mask;
    found     = |free_bits;
    bit_idx   = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        bit_idx = BIT_W'(b);
      end
    end
  end

  assign res.found    = found;
  assign res.bit_idx  = bit_idx;
  assign res.set_word = word | (WORD_W'(1) << bit_idx);
  assign res.lim_mask = mask;

endmodule

// ===== hdl/bitmap_frame_allocator_unit.sv =====
// Top level: bitmap frame allocator with sequencer, map RAM and word unit.
//
// Requests arrive on in_ch (operation, address) and each gives exactly one
// result on out_ch (status, frame_address, is_free). in_ch.ready is high only
// while the sequencer is idle; one request is worked on at a time.
// Work done from request transfer to result valid:
//   allocate     : scans map words from word 0 up, 1 .. MAP_WORDS (128) of them
//   free, query  : one read of the frame's word, plus a write for free; out-of-range address: no map access
//   init         : rewrites all MAP_WORDS (128) map words
// Rate is set by the single map RAM read port and the shared word unit, which
// look at one 32-frame word per cycle.
// cfg_we writes the reserved-region end address from cfg_wdata; write only while idle.
// Reset (rst_n low, synchronous) empties the map at once: a per-word valid
// flag makes an unwritten word read as all free, so there is no clearing pass.
// A result waits in the output register while out_ch.ready is low; the block
// holds the next result until that transfer completes.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bitmap_frame_allocator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  bfa_in_if.sink                      in_ch,
  bfa_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [bfa_pkg::ADDR_W-1:0]  cfg_wdata
);
  import bfa_pkg::*;

  state_t                 state_r, state_nxt;
  logic [WADDR_W-1:0]     chk_r, chk_nxt;
  logic [FRAME_IDX_W-1:0] fr_r, fr_nxt;
  op_t                    op_r, op_nxt;
  logic [LIM_W-1:0]       lim_r, lim_nxt;
  logic [ADDR_W-1:0]      resv_end_r;
  logic [MAP_WORDS-1:0]   wvalid_r, wvalid_nxt;

  status_t                res_status_r, res_status_nxt;
  logic [ADDR_W-1:0]      res_fa_r, res_fa_nxt;
  logic                   res_free_r, res_free_nxt;

  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r;
  logic [ADDR_W-1:0]      out_fa_r;
  logic                   out_free_r;
  logic                   out_load;

  logic                   ram_we;
  logic [WORD_W-1:0]      ram_wdata;
  logic [WADDR_W-1:0]     ram_raddr;
  logic [WORD_W-1:0]      ram_rdata;
  logic [WORD_W-1:0]      word_eff;
  logic [LIM_W-1:0]       unit_lim;
  word_res_t              unit_res;

  logic [ADDR_W-1:0]      in_frame;
  logic [ADDR_W:0]        resv_frames;
  logic                   accept;
  op_t                    in_op;

  bfa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (chk_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read data belongs to word chk_r; a word never written since reset is free.
  assign word_eff = wvalid_r[chk_r] ? ram_rdata : '0;
  assign unit_lim = (state_r == S_INIT) ? lim_r : USABLE_LIM;

  bfa_word_unit u_unit (
    .word     (word_eff),
    .word_idx (chk_r),
    .limit    (unit_lim),
    .res      (unit_res)
  );

  assign in_op     = op_t'(in_ch.operation);
  assign in_frame  = in_ch.address >> FRAME_SHIFT;
  assign accept    = in_ch.valid && in_ch.ready;
  // Frames reserved by init: ceiling of the reserved end over the frame size.
  assign resv_frames = (ADDR_W + 1)'(resv_end_r >> FRAME_SHIFT)
                     + (ADDR_W + 1)'((resv_end_r & ADDR_W'(FRAME_BYTES - 1)) != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wvalid_r    <= '0;
      out_valid_r <= 1'b0;
      resv_end_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      wvalid_r    <= wvalid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        resv_end_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_r        <= chk_nxt;
    fr_r         <= fr_nxt;
    op_r         <= op_nxt;
    lim_r        <= lim_nxt;
    res_status_r <= res_status_nxt;
    res_fa_r     <= res_fa_nxt;
    res_free_r   <= res_free_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_fa_r     <= res_fa_r;
      out_free_r   <= res_free_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    chk_nxt        = chk_r;
    fr_nxt         = fr_r;
    op_nxt         = op_r;
    lim_nxt        = lim_r;
    res_status_nxt = res_status_r;
    res_fa_nxt     = res_fa_r;
    res_free_nxt   = res_free_r;
    wvalid_nxt     = wvalid_r;
    ram_we         = 1'b0;
    ram_wdata      = unit_res.set_word;
    ram_raddr      = chk_r + WADDR_W'(1);
    in_ch.ready    = 1'b0;
    out_load       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          op_nxt         = in_op;
          res_status_nxt = ST_DONE;
          res_fa_nxt     = '0;
          res_free_nxt   = 1'b0;
          unique case (in_op)
            OP_ALLOC: begin
              ram_raddr = '0;
              chk_nxt   = '0;
              state_nxt = S_SCAN;
            end
            OP_FREE, OP_QUERY: begin
              if (in_frame >= ADDR_W'(FRAME_COUNT)) begin
                res_status_nxt = ST_RANGE;
                state_nxt      = S_FIN;
              end else begin
                fr_nxt    = in_frame[FRAME_IDX_W-1:0];
                ram_raddr = in_frame[FRAME_IDX_W-1:BIT_W];
                chk_nxt   = in_frame[FRAME_IDX_W-1:BIT_W];
                state_nxt = S_RMW;
              end
            end
            OP_INIT: begin
              lim_nxt   = (resv_frames >= (ADDR_W + 1)'(FRAME_COUNT)) ?
                          LIM_W'(FRAME_COUNT) : resv_frames[LIM_W-1:0];
              chk_nxt   = '0;
              state_nxt = S_INIT;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (unit_res.found) begin
          ram_we            = 1'b1;
          ram_wdata         = unit_res.set_word;
          wvalid_nxt[chk_r] = 1'b1;
          res_fa_nxt        = ADDR_W'({chk_r, unit_res.bit_idx}) << FRAME_SHIFT;
          state_nxt         = S_FIN;
        end else if (chk_r == WADDR_W'(MAP_WORDS - 1)) begin
          res_status_nxt = ST_NO_FREE;
          state_nxt      = S_FIN;
        end else begin
          chk_nxt = chk_r + WADDR_W'(1);
        end
      end
      S_RMW: begin
        if (op_r == OP_FREE) begin
          ram_we            = 1'b1;
          ram_wdata         = word_eff & ~(WORD_W'(1) << fr_r[BIT_W-1:0]);
          wvalid_nxt[chk_r] = 1'b1;
        end else begin
          res_free_nxt = ~word_eff[fr_r[BIT_W-1:0]];
        end
        state_nxt = S_FIN;
      end
      S_INIT: begin
        // Overwrite every word, so the whole map is rebuilt in one sweep.
        ram_we            = 1'b1;
        ram_wdata         = unit_res.lim_mask;
        wvalid_nxt[chk_r] = 1'b1;
        if (chk_r == WADDR_W'(MAP_WORDS - 1)) begin
          state_nxt = S_FIN;
        end else begin
          chk_nxt = chk_r + WADDR_W'(1);
        end
      end
      S_FIN: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt        = out_load || (out_valid_r && !out_ch.ready);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.frame_address = out_fa_r;
  assign out_ch.is_free       = out_free_r;

  `BFA_ASSERT_NEXT(a_accept_leaves_idle, accept, state_r != S_IDLE, "accept did not start work")
  `BFA_ASSERT(a_write_when_busy,
    !ram_we || state_r == S_SCAN || state_r == S_RMW || state_r == S_INIT,
    "map write outside a working state")
  `BFA_ASSERT(a_fa_aligned,
    !out_valid_r || (out_fa_r & ADDR_W'(FRAME_BYTES - 1)) == '0,
    "frame address not frame aligned")
  `BFA_ASSERT(a_fail_clean,
    !out_valid_r || out_status_r == ST_DONE || (out_fa_r == '0 && !out_free_r),
    "failed result carries data")
  `BFA_ASSERT(a_free_no_addr,
    !out_valid_r || !out_free_r || out_fa_r == '0,
    "query result with frame address")

endmodule

// ===== tb/bitmap_frame_allocator_unit_tb.sv =====
// Testbench: predicts and checks every allocator result through a small frame-map scoreboard.
`timescale 1ns / 1ps

module bitmap_frame_allocator_unit_tb;
  import bfa_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    status_t           status;
    logic [ADDR_W-1:0] frame_address;
    logic              is_free;
  } alloc_result_t;

  class frame_map_scoreboard;
    bit                 used_frames[FRAME_COUNT];
    logic [ADDR_W-1:0]  resv_end;
    alloc_result_t      expected_results[$];
    int                 errors;

    function new();
      foreach (used_frames[f]) used_frames[f] = 1'b0;
      resv_end = '0;
      errors   = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // Apply one accepted request to the frame map and queue the result it must give.
    function void note_request(op_t op, logic [ADDR_W-1:0] addr);
      alloc_result_t   res;
      longint unsigned span;
      longint unsigned limit;
      longint unsigned frame;
      bit              found;
      res.status        = ST_DONE;
      res.frame_address = '0;
      res.is_free       = 1'b0;
      case (op)
        OP_ALLOC: begin
          // frames whose start address does not fit in 32 bits count as used
          span  = ((64'd1 << ADDR_W) + FRAME_BYTES - 1) / FRAME_BYTES;
          limit = (span < FRAME_COUNT) ? span : FRAME_COUNT;
          found = 1'b0;
          for (longint unsigned f = 0; f < limit && !found; f++) begin
            if (!used_frames[f]) begin
              used_frames[f]    = 1'b1;
              res.frame_address = ADDR_W'(f * FRAME_BYTES);
              found             = 1'b1;
            end
          end
          if (!found) res.status = ST_NO_FREE;
        end
        OP_FREE, OP_QUERY: begin
          frame = longint'(addr) / FRAME_BYTES;
          if (frame >= FRAME_COUNT) begin
            res.status = ST_RANGE;
          end else if (op == OP_FREE) begin
            used_frames[frame] = 1'b0;
          end else begin
            res.is_free = !used_frames[frame];
          end
        end
        default: begin
          for (longint unsigned f = 0; f < FRAME_COUNT; f++)
            used_frames[f] = (f * FRAME_BYTES < longint'(resv_end));
        end
      endcase
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] frame_address,
                               logic is_free);
      alloc_result_t exp_res;
      if (expected_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        errors++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (status !== exp_res.status) begin
        $error("status: expected %0d, actual %0d", exp_res.status, status);
        errors++;
      end
      if (frame_address !== exp_res.frame_address) begin
        $error("frame_address: expected 0x%08h, actual 0x%08h", exp_res.frame_address,
               frame_address);
        errors++;
      end
      if (is_free !== exp_res.is_free) begin
        $error("is_free: expected %0d, actual %0d", exp_res.is_free, is_free);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [ADDR_W-1:0]  cfg_wdata;
  int                 tx_idle_pct;
  int                 rx_idle_pct;
  logic               hold_req;
  int                 stall_cycles = 0;

  frame_map_scoreboard map_sb = new();

  bfa_in_if  in_ch();
  bfa_out_if out_ch();

  bitmap_frame_allocator_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Monitor: note requests before results so same-edge transfers stay in order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        map_sb.note_request(op_t'(in_ch.operation), in_ch.address);
      if (out_ch.valid && out_ch.ready)
        map_sb.check_result(out_ch.status, out_ch.frame_address, out_ch.is_free);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_request(op_t op, logic [ADDR_W-1:0] addr);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.address   <= addr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (map_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_resv_end(logic [ADDR_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    map_sb.resv_end = value;
  endtask

  task automatic send_random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)
      send_request(OP_ALLOC, $urandom());
    else if (r < 65)
      send_request(OP_FREE, $urandom_range(0, 32'h00FF_FFFF));
    else if (r < 85)
      send_request(OP_QUERY, $urandom_range(0, 32'h00FF_FFFF));
    else if (r < 90)
      send_request(OP_INIT, $urandom());
    else if (r < 95)
      send_request(OP_FREE, $urandom_range(32'h0100_0000, 32'hFFFF_FFFF));
    else
      send_request(OP_QUERY, $urandom_range(32'h0100_0000, 32'hFFFF_FFFF));
  endtask

  task automatic run_random_phase(int tx_pct, int rx_pct, logic [ADDR_W-1:0] kend,
                                  int count);
    write_resv_end(kend);
    tx_idle_pct <= tx_pct;
    rx_idle_pct <= rx_pct;
    send_request(OP_INIT, $urandom());
    repeat (count) send_random_request();
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_ALLOC;
    in_ch.address   <= '0;
    tx_idle_pct     <= 0;
    rx_idle_pct     <= 0;
    hold_req        <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset map, range edges, double free, full map, kernel region.
    send_request(OP_ALLOC, 32'h0000_0000);
    send_request(OP_ALLOC, 32'hFFFF_FFFF);
    send_request(OP_QUERY, 32'h0000_0000);
    send_request(OP_QUERY, 32'h0000_2FFF);
    send_request(OP_FREE,  32'h0000_0ABC);
    send_request(OP_QUERY, 32'h0000_0000);
    send_request(OP_ALLOC, 32'h0000_0000);
    send_request(OP_FREE,  32'hFFFF_FFFF);
    send_request(OP_QUERY, 32'h0100_0000);
    send_request(OP_QUERY, 32'h00FF_FFFF);
    send_request(OP_FREE,  32'h00FF_F000);
    send_request(OP_INIT,  32'h0000_0000);
    send_request(OP_QUERY, 32'h0000_1000);
    write_resv_end(32'hFFFF_FFFF);
    send_request(OP_INIT,  32'h0000_0000);
    send_request(OP_ALLOC, 32'h0000_0000);
    send_request(OP_QUERY, 32'h00FF_FFFF);
    send_request(OP_FREE,  32'h00FF_F123);
    send_request(OP_ALLOC, 32'h0000_0000);
    send_request(OP_ALLOC, 32'h0000_0000);
    write_resv_end(32'h0000_1001);
    send_request(OP_INIT,  32'h0000_0000);
    send_request(OP_ALLOC, 32'h0000_0000);
    send_request(OP_QUERY, 32'h0000_1FFF);
    send_request(OP_FREE,  32'h0000_0000);
    send_request(OP_ALLOC, 32'h0000_0000);

    // Random: small kernel, nearly full map, then mostly reserved map under hold-off.
    run_random_phase(20, 58, $urandom_range(0, 32'h0020_0000), 125);
    run_random_phase(58, 20, $urandom_range(32'h00FF_0000, 32'h0100_0000), 125);
    hold_req <= 1'b1;
    run_random_phase(0, 0, $urandom(), 125);

    drain();
    if (map_sb.errors == 0 && map_sb.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
